// ----- hw/rtl/bcd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_pkg: shared definitions for the bytecode instruction decoder
// Opcode constants, operand kind and status codes, and the result record.
// ----------------------------------------------------------------------------
package bcd_pkg;

    localparam int OFFSET_BITS_DEF = 16;

    // Operand bytes gathered after an opcode (wide iinc is the longest).
    localparam int OPND_DEPTH = 5;
    localparam int OPND_IDX_BITS = $clog2(OPND_DEPTH);

    localparam int RESULT_DATA_BITS = 112;
    localparam int RESULT_USER_BITS = 2;

    localparam logic [7:0] OP_IINC        = 8'h84;
    localparam logic [7:0] OP_WIDE        = 8'hc4;
    localparam logic [7:0] OP_INVOKEIFACE = 8'hb9;
    localparam logic [7:0] OP_MULTIANEW   = 8'hc5;
    localparam logic [7:0] OP_NEWARRAY    = 8'hbc;
    localparam logic [7:0] OP_LDC         = 8'h12;
    localparam logic [7:0] OP_SIPUSH      = 8'h11;
    localparam logic [7:0] OP_BIPUSH      = 8'h10;
    localparam logic [7:0] OP_GOTO_W      = 8'hc8;
    localparam logic [7:0] OP_JSR_W       = 8'hc9;
    localparam logic [7:0] OP_RET         = 8'ha9;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_POOL   = 3'd1;
    localparam logic [2:0] KIND_LOCAL  = 3'd2;
    localparam logic [2:0] KIND_IMM    = 3'd3;
    localparam logic [2:0] KIND_BRANCH = 3'd4;
    localparam logic [2:0] KIND_ATYPE  = 3'd5;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_INVALID  = 2'd1;
    localparam logic [1:0] STAT_TRUNC    = 2'd2;
    localparam logic [1:0] STAT_RESERVED = 2'd3;

    localparam logic [2:0] LEN_INVALID = 3'd0;
    localparam logic [2:0] LEN_ONE     = 3'd1;
    localparam logic [2:0] LEN_TWO     = 3'd2;
    localparam logic [2:0] LEN_WIDE    = 3'd4;
    localparam logic [2:0] LEN_LONG    = 3'd5;
    localparam logic [2:0] LEN_WIDE_IINC = 3'd6;

    typedef struct packed {
        logic [2:0] len;
        logic [2:0] kind;
    } bcd_class_t;

    typedef struct packed {
        logic [15:0]        instr_offset;
        logic [7:0]         opcode;
        logic               wide_prefix;
        logic [2:0]         instr_length;
        logic [2:0]         operand_kind;
        logic signed [31:0] operand_a;
        logic signed [15:0] operand_b;
        logic signed [31:0] branch_target;
        logic [1:0]         status;
        logic               stream_end;
    } bcd_result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bcd_classify.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_classify: opcode length and operand kind table
// Gives the total instruction length (0 for an invalid opcode) and the kind.
// ----------------------------------------------------------------------------
module bcd_classify import bcd_pkg::*; (
    input  wire logic [7:0] opcode,
    output bcd_class_t      cls
);

    always_comb begin
        cls = '{len: LEN_INVALID, kind: KIND_NONE};
        case (opcode) inside
            [8'h00:8'h0f], [8'h1a:8'h35], [8'h3b:8'h83], [8'h85:8'h98],
            [8'hac:8'hb1], 8'hbe, 8'hbf, 8'hc2, 8'hc3: begin
                cls = '{len: LEN_ONE, kind: KIND_NONE};
            end
            OP_LDC:      cls = '{len: LEN_TWO, kind: KIND_POOL};
            OP_NEWARRAY: cls = '{len: LEN_TWO, kind: KIND_ATYPE};
            OP_BIPUSH:   cls = '{len: LEN_TWO, kind: KIND_IMM};
            [8'h15:8'h19], [8'h36:8'h3a], OP_RET: begin
                cls = '{len: LEN_TWO, kind: KIND_LOCAL};
            end
            OP_SIPUSH:   cls = '{len: 3'd3, kind: KIND_IMM};
            OP_IINC:     cls = '{len: 3'd3, kind: KIND_LOCAL};
            8'h13, 8'h14, [8'hb2:8'hb8], 8'hbb, 8'hbd, 8'hc0, 8'hc1: begin
                cls = '{len: 3'd3, kind: KIND_POOL};
            end
            [8'h99:8'ha8], 8'hc6, 8'hc7: begin
                cls = '{len: 3'd3, kind: KIND_BRANCH};
            end
            OP_MULTIANEW:        cls = '{len: 3'd4, kind: KIND_POOL};
            OP_INVOKEIFACE:      cls = '{len: LEN_LONG, kind: KIND_POOL};
            OP_GOTO_W, OP_JSR_W: cls = '{len: LEN_LONG, kind: KIND_BRANCH};
            OP_WIDE:             cls = '{len: LEN_WIDE, kind: KIND_LOCAL};
            default:             cls = '{len: LEN_INVALID, kind: KIND_NONE};
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/bcd_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_decode: instruction gathering and operand decode
// Holds the per-instruction state and forms at most one result per byte.
// ----------------------------------------------------------------------------
module bcd_decode import bcd_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_accept,
    input  wire logic [7:0] code_byte,
    input  wire logic       end_of_code,
    output logic            res_valid,
    output bcd_result_t     res
);

    bcd_class_t cls;

    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [7:0]             held_reg, held_next;
    logic                   wide_reg, wide_next;
    logic [2:0]             len_reg, len_next;
    logic [2:0]             kind_reg, kind_next;
    logic [2:0]             need_reg, need_next;
    logic [2:0]             got_reg, got_next;
    logic                   halted_reg, halted_next;
    logic [7:0]             opnd_reg [OPND_DEPTH];

    logic [7:0]  eff [OPND_DEPTH];
    logic [2:0]  need_after;
    logic        opnd_we;
    bcd_result_t fin_res;

    bcd_classify u_classify (
        .opcode (code_byte),
        .cls    (cls)
    );

    // Operand bytes as seen once the current byte has been added.
    always_comb begin
        for (int i = 0; i < OPND_DEPTH; i++) begin
            eff[i] = (got_reg == 3'(i)) ? code_byte : opnd_reg[i];
        end
    end

    always_comb begin
        need_after = need_reg - 3'd1;
        if (wide_reg && got_reg == 3'd0 && code_byte == OP_IINC) begin
            need_after = need_after + 3'd2;
        end
    end

    // Result of a completed multi-byte instruction.
    always_comb begin
        logic [15:0] w16;
        w16 = {eff[0], eff[1]};
        fin_res = '0;
        fin_res.instr_offset = 16'(start_reg);
        fin_res.opcode       = held_reg;
        fin_res.wide_prefix  = wide_reg;
        fin_res.instr_length = len_reg;
        fin_res.operand_kind = kind_reg;
        fin_res.status       = STAT_OK;
        fin_res.stream_end   = end_of_code;
        if (wide_reg) begin
            fin_res.opcode       = eff[0];
            fin_res.operand_a    = {16'd0, eff[1], eff[2]};
            fin_res.instr_length = LEN_WIDE;
            fin_res.operand_kind = KIND_LOCAL;
            if (eff[0] == OP_IINC) begin
                fin_res.operand_b    = {eff[3], eff[4]};
                fin_res.instr_length = LEN_WIDE_IINC;
            end
        end else if (held_reg == OP_BIPUSH) begin
            fin_res.operand_a = {{24{eff[0][7]}}, eff[0]};
        end else if (len_reg == LEN_TWO) begin
            fin_res.operand_a = {24'd0, eff[0]};
        end else if (held_reg == OP_SIPUSH) begin
            fin_res.operand_a = {{16{w16[15]}}, w16};
        end else if (held_reg == OP_IINC) begin
            fin_res.operand_a = {24'd0, eff[0]};
            fin_res.operand_b = {{8{eff[1][7]}}, eff[1]};
        end else if (held_reg == OP_MULTIANEW || held_reg == OP_INVOKEIFACE) begin
            fin_res.operand_a = {16'd0, w16};
            fin_res.operand_b = {8'd0, eff[2]};
            if (held_reg == OP_INVOKEIFACE && eff[3] != 8'd0) begin
                fin_res.status = STAT_RESERVED;
            end
        end else if (kind_reg == KIND_BRANCH) begin
            if (len_reg == LEN_LONG) begin
                fin_res.operand_a = {eff[0], eff[1], eff[2], eff[3]};
            end else begin
                fin_res.operand_a = {{16{w16[15]}}, w16};
            end
            fin_res.branch_target = 32'(start_reg) + fin_res.operand_a;
        end else begin
            fin_res.operand_a = {16'd0, w16};
        end
    end

    always_comb begin
        pos_next    = pos_reg;
        start_next  = start_reg;
        held_next   = held_reg;
        wide_next   = wide_reg;
        len_next    = len_reg;
        kind_next   = kind_reg;
        need_next   = need_reg;
        got_next    = got_reg;
        halted_next = halted_reg;
        opnd_we     = 1'b0;
        res_valid   = 1'b0;
        res         = '0;

        if (in_accept) begin
            if (halted_reg) begin
                if (end_of_code) begin
                    pos_next    = '0;
                    start_next  = '0;
                    held_next   = '0;
                    wide_next   = 1'b0;
                    need_next   = '0;
                    got_next    = '0;
                    halted_next = 1'b0;
                end
            end else begin
                if (need_reg == 3'd0) begin
                    start_next = pos_reg;
                    if (cls.len == LEN_INVALID || cls.len == LEN_ONE) begin
                        res_valid          = 1'b1;
                        res.instr_offset   = 16'(pos_reg);
                        res.opcode         = code_byte;
                        res.instr_length   = LEN_ONE;
                        res.operand_kind   = KIND_NONE;
                        res.status         = (cls.len == LEN_INVALID) ? STAT_INVALID : STAT_OK;
                        res.stream_end     = end_of_code;
                        if (cls.len == LEN_INVALID && !end_of_code) begin
                            halted_next = 1'b1;
                        end
                    end else begin
                        held_next = code_byte;
                        wide_next = (code_byte == OP_WIDE);
                        len_next  = cls.len;
                        kind_next = cls.kind;
                        need_next = cls.len - 3'd1;
                        got_next  = '0;
                    end
                end else begin
                    opnd_we   = 1'b1;
                    got_next  = got_reg + 3'd1;
                    need_next = need_after;
                    if (need_after == 3'd0) begin
                        res_valid = 1'b1;
                        res       = fin_res;
                        held_next = '0;
                        wide_next = 1'b0;
                        got_next  = '0;
                    end
                end

                pos_next = pos_reg + OFFSET_BITS'(1);

                if (end_of_code) begin
                    // An instruction still open at the end of the array is cut short.
                    if (!res_valid && need_next != 3'd0) begin
                        res_valid        = 1'b1;
                        res.instr_offset = 16'(start_next);
                        res.opcode       = (wide_next && got_next != 3'd0) ? eff[0] : held_next;
                        res.wide_prefix  = wide_next;
                        res.instr_length = got_next + 3'd1;
                        res.operand_kind = kind_next;
                        res.status       = STAT_TRUNC;
                        res.stream_end   = 1'b1;
                    end
                    pos_next    = '0;
                    start_next  = '0;
                    held_next   = '0;
                    wide_next   = 1'b0;
                    need_next   = '0;
                    got_next    = '0;
                    halted_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            start_reg  <= '0;
            held_reg   <= '0;
            wide_reg   <= 1'b0;
            len_reg    <= '0;
            kind_reg   <= '0;
            need_reg   <= '0;
            got_reg    <= '0;
            halted_reg <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            held_reg   <= held_next;
            wide_reg   <= wide_next;
            len_reg    <= len_next;
            kind_reg   <= kind_next;
            need_reg   <= need_next;
            got_reg    <= got_next;
            halted_reg <= halted_next;
        end
    end

    // Operand bytes are payload; every byte read is written earlier in the instruction.
    always_ff @(posedge aclk) begin
        if (opnd_we && got_reg < 3'(OPND_DEPTH)) begin
            opnd_reg[got_reg[OPND_IDX_BITS-1:0]] <= code_byte;
        end
    end

`ifndef SYNTHESIS
    a_halt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> (need_reg == 3'd0))
        else $error("decoder halted with an instruction open");
    a_got_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (got_reg <= 3'(OPND_DEPTH)))
        else $error("operand byte count out of range");
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && end_of_code) |=> (pos_reg == '0 && need_reg == 3'd0 && !halted_reg))
        else $error("decode state not cleared after end of code");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/bcd_out_buf.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_out_buf: two-entry result buffer
// Decouples the result channel from the byte channel so input keeps flowing.
// ----------------------------------------------------------------------------
module bcd_out_buf import bcd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire bcd_result_t push_data,
    output logic             ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output bcd_result_t      out_data
);

    logic [1:0]  cnt_reg, cnt_next;
    bcd_result_t head_reg, head_next;
    bcd_result_t tail_reg, tail_next;
    logic        pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = head_reg;
    assign ready     = (cnt_reg != 2'd2);

    always_comb begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (push && pop) begin
            if (cnt_reg == 2'd1) begin
                head_next = push_data;
            end else begin
                head_next = tail_reg;
                tail_next = push_data;
            end
        end else if (push) begin
            if (cnt_reg == 2'd0) begin
                head_next = push_data;
            end else begin
                tail_next = push_data;
            end
            cnt_next = cnt_reg + 2'd1;
        end else if (pop) begin
            head_next = tail_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != 2'd3))
        else $error("result buffer count out of range");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !push)
        else $error("result pushed into a full buffer");
    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> out_valid)
        else $error("pushed result not presented");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/bytecode_instruction_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bytecode_instruction_decoder: JVM bytecode instruction length decoder
// Groups a stream of code bytes into instructions and reports each one.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload                                   | Marker
//  --------+-----------+-------------------------------------------+---------------
//  s_      | in        | tdata[7:0] code byte                      | tlast end_of_code
//  m_      | out       | tdata: instruction record (see port list) | tlast stream_end
//
//  A new byte can be taken every cycle while s_tready is high; the rate is set
//  by the single decode pass from the held instruction state to the result
//  buffer. A record is written into the result buffer with the byte that
//  completes its instruction and is presented on m_ from there. Reset (aresetn
//  low at a clock edge) clears the decode state and empties the two-entry
//  result buffer. s_tready drops only while both entries wait on m_tready.
//
// The decoder tracks the byte position within the code array, the opcode of
// the open instruction and the operand bytes gathered so far. An invalid
// opcode is reported and the rest of the array is skipped up to its last
// byte. An instruction still open at the last byte is reported as truncated.
// The last byte of an array returns all state to zero for the next one.
module bytecode_instruction_decoder import bcd_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] code_byte
    input  wire logic                        s_tlast,   // end_of_code

    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [15:0] instr_offset, [23:16] opcode, [24] wide_prefix, [27:25] instr_length,
    // [30:28] operand_kind, [62:31] operand_a, [78:63] operand_b,
    // [110:79] branch_target, [111] zero
    output logic [RESULT_DATA_BITS-1:0]      m_tdata,
    output logic [RESULT_USER_BITS-1:0]      m_tuser,   // [1:0] status
    output logic                             m_tlast    // stream_end
);

    logic        in_accept;
    logic        res_valid;
    bcd_result_t res;
    bcd_result_t out_res;

    // A byte transaction completes when both sides of the handshake agree.
    assign in_accept = s_tvalid && s_tready;

    bcd_decode #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .code_byte   (s_tdata),
        .end_of_code (s_tlast),
        .res_valid   (res_valid),
        .res         (res)
    );

    // The buffer holds up to two results, so input keeps flowing while the
    // result channel stalls and a buffer entry is still free.
    bcd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {1'b0,
                      out_res.branch_target,
                      out_res.operand_b,
                      out_res.operand_a,
                      out_res.operand_kind,
                      out_res.instr_length,
                      out_res.wide_prefix,
                      out_res.opcode,
                      out_res.instr_offset};
    assign m_tuser = out_res.status;
    assign m_tlast = out_res.stream_end;

endmodule
`default_nettype wire

// ----- tb/tb_bytecode_instruction_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bytecode_instruction_decoder: self-checking bench for the bytecode decoder
// Streams JVM code arrays into the decoder and predicts every instruction
// record in the bench. Each record on the result channel is compared field
// by field with the oldest prediction. The stimulus runs a short directed
// array set, branches whose targets wrap the 32-bit range, a long receiver
// hold-off and randomized arrays under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_bytecode_instruction_decoder import bcd_pkg::*; ();

    // Opcodes that bound the classes of the instruction set. The package
    // names only the opcodes that need special handling.
    localparam logic [7:0] OP_NOP          = 8'h00;
    localparam logic [7:0] OP_DCONST_1     = 8'h0f;
    localparam logic [7:0] OP_LDC_W        = 8'h13;
    localparam logic [7:0] OP_LDC2_W       = 8'h14;
    localparam logic [7:0] OP_ILOAD        = 8'h15;
    localparam logic [7:0] OP_ALOAD        = 8'h19;
    localparam logic [7:0] OP_ILOAD_0      = 8'h1a;
    localparam logic [7:0] OP_SALOAD       = 8'h35;
    localparam logic [7:0] OP_ISTORE       = 8'h36;
    localparam logic [7:0] OP_ASTORE       = 8'h3a;
    localparam logic [7:0] OP_ISTORE_0     = 8'h3b;
    localparam logic [7:0] OP_LXOR         = 8'h83;
    localparam logic [7:0] OP_I2L          = 8'h85;
    localparam logic [7:0] OP_DCMPG        = 8'h98;
    localparam logic [7:0] OP_IFEQ         = 8'h99;
    localparam logic [7:0] OP_GOTO         = 8'ha7;
    localparam logic [7:0] OP_JSR          = 8'ha8;
    localparam logic [7:0] OP_TABLESWITCH  = 8'haa;
    localparam logic [7:0] OP_IRETURN      = 8'hac;
    localparam logic [7:0] OP_RETURN       = 8'hb1;
    localparam logic [7:0] OP_GETSTATIC    = 8'hb2;
    localparam logic [7:0] OP_INVOKESTATIC = 8'hb8;
    localparam logic [7:0] OP_NEW          = 8'hbb;
    localparam logic [7:0] OP_ANEWARRAY    = 8'hbd;
    localparam logic [7:0] OP_ARRAYLENGTH  = 8'hbe;
    localparam logic [7:0] OP_ATHROW       = 8'hbf;
    localparam logic [7:0] OP_CHECKCAST    = 8'hc0;
    localparam logic [7:0] OP_INSTANCEOF   = 8'hc1;
    localparam logic [7:0] OP_MONITORENTER = 8'hc2;
    localparam logic [7:0] OP_MONITOREXIT  = 8'hc3;
    localparam logic [7:0] OP_IFNULL       = 8'hc6;
    localparam logic [7:0] OP_IFNONNULL    = 8'hc7;

    // A cycle without any transaction on either channel counts toward the
    // watchdog. The longest legal quiet stretch is the receiver hold-off.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_SHOWN = 50;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [RESULT_DATA_BITS-1:0] m_tdata;
    logic [RESULT_USER_BITS-1:0] m_tuser;
    logic        m_tlast;

    bytecode_instruction_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Idle mix of both channels, in percent of cycles.
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_req = 0;

    int err_count = 0;
    int bytes_sent = 0;
    int live_bytes = 0;
    int arrays_sent = 0;
    int results_seen = 0;
    int idle_cycles = 0;

    bcd_result_t expected_instrs[$];
    logic [7:0]  code_buf[$];

    // Decoder state as seen by the bench.
    logic [15:0] pos_q;
    logic [15:0] start_q;
    logic [7:0]  held_q;
    logic        wide_q;
    logic        halt_q;
    logic [2:0]  need_q;
    logic [2:0]  got_q;
    logic [39:0] opnd_q;

    function automatic void decoder_clear();
        pos_q = '0;
        start_q = '0;
        held_q = '0;
        wide_q = 1'b0;
        halt_q = 1'b0;
        need_q = '0;
        got_q = '0;
        opnd_q = '0;
    endfunction

    // Total length and operand kind of an opcode; length 0 marks an opcode
    // that the decoder rejects, tableswitch and lookupswitch among them.
    function automatic bcd_class_t op_class(input logic [7:0] op);
        bcd_class_t c;
        c.len = LEN_INVALID;
        c.kind = KIND_NONE;
        if (op <= OP_DCONST_1 || (op >= OP_ILOAD_0 && op <= OP_SALOAD) ||
            (op >= OP_ISTORE_0 && op <= OP_LXOR) || (op >= OP_I2L && op <= OP_DCMPG) ||
            (op >= OP_IRETURN && op <= OP_RETURN) || op == OP_ARRAYLENGTH ||
            op == OP_ATHROW || op == OP_MONITORENTER || op == OP_MONITOREXIT) begin
            c.len = LEN_ONE;
        end else if (op == OP_LDC) begin
            c.len = LEN_TWO;
            c.kind = KIND_POOL;
        end else if (op == OP_NEWARRAY) begin
            c.len = LEN_TWO;
            c.kind = KIND_ATYPE;
        end else if (op == OP_BIPUSH) begin
            c.len = LEN_TWO;
            c.kind = KIND_IMM;
        end else if ((op >= OP_ILOAD && op <= OP_ALOAD) ||
                     (op >= OP_ISTORE && op <= OP_ASTORE) || op == OP_RET) begin
            c.len = LEN_TWO;
            c.kind = KIND_LOCAL;
        end else if (op == OP_SIPUSH) begin
            c.len = 3'd3;
            c.kind = KIND_IMM;
        end else if (op == OP_IINC) begin
            c.len = 3'd3;
            c.kind = KIND_LOCAL;
        end else if (op == OP_LDC_W || op == OP_LDC2_W ||
                     (op >= OP_GETSTATIC && op <= OP_INVOKESTATIC) || op == OP_NEW ||
                     op == OP_ANEWARRAY || op == OP_CHECKCAST || op == OP_INSTANCEOF) begin
            c.len = 3'd3;
            c.kind = KIND_POOL;
        end else if ((op >= OP_IFEQ && op <= OP_JSR) || op == OP_IFNULL ||
                     op == OP_IFNONNULL) begin
            c.len = 3'd3;
            c.kind = KIND_BRANCH;
        end else if (op == OP_MULTIANEW) begin
            c.len = 3'd4;
            c.kind = KIND_POOL;
        end else if (op == OP_INVOKEIFACE) begin
            c.len = LEN_LONG;
            c.kind = KIND_POOL;
        end else if (op == OP_GOTO_W || op == OP_JSR_W) begin
            c.len = LEN_LONG;
            c.kind = KIND_BRANCH;
        end else if (op == OP_WIDE) begin
            c.len = LEN_WIDE;
            c.kind = KIND_LOCAL;
        end
        return c;
    endfunction

    // Operand byte idx (counted from 1) of the open instruction.
    function automatic logic [7:0] opnd_byte(input int idx);
        logic [39:0] t;
        if (idx < 1 || idx > int'(got_q))
            return 8'h00;
        t = opnd_q >> (8 * (int'(got_q) - idx));
        return t[7:0];
    endfunction

    // Record of the held instruction once its last operand byte has come.
    function automatic bcd_result_t completed_instr(input logic last);
        bcd_result_t r;
        bcd_class_t  c;
        logic [15:0] w16;
        c = op_class(held_q);
        w16 = {opnd_byte(1), opnd_byte(2)};
        r = '0;
        r.instr_offset = start_q;
        r.opcode = held_q;
        r.wide_prefix = wide_q;
        r.instr_length = c.len;
        r.operand_kind = c.kind;
        r.status = STAT_OK;
        r.stream_end = last;
        if (wide_q) begin
            r.opcode = opnd_byte(1);
            r.operand_a = {16'h0000, opnd_byte(2), opnd_byte(3)};
            r.instr_length = LEN_WIDE;
            if (r.opcode == OP_IINC) begin
                r.operand_b = {opnd_byte(4), opnd_byte(5)};
                r.instr_length = LEN_WIDE_IINC;
            end
            r.operand_kind = KIND_LOCAL;
        end else if (held_q == OP_BIPUSH) begin
            r.operand_a = {{24{w16[15]}}, w16[15:8]};
        end else if (c.len == LEN_TWO) begin
            r.operand_a = {24'h000000, w16[15:8]};
        end else if (held_q == OP_SIPUSH) begin
            r.operand_a = {{16{w16[15]}}, w16};
        end else if (held_q == OP_IINC) begin
            r.operand_a = {24'h000000, w16[15:8]};
            r.operand_b = {{8{w16[7]}}, w16[7:0]};
        end else if (held_q == OP_MULTIANEW || held_q == OP_INVOKEIFACE) begin
            r.operand_a = {16'h0000, w16};
            r.operand_b = {8'h00, opnd_byte(3)};
            if (held_q == OP_INVOKEIFACE && opnd_byte(4) != 8'h00)
                r.status = STAT_RESERVED;
        end else if (c.kind == KIND_BRANCH) begin
            if (c.len == LEN_LONG)
                r.operand_a = {w16, opnd_byte(3), opnd_byte(4)};
            else
                r.operand_a = {{16{w16[15]}}, w16};
            r.branch_target = {16'h0000, start_q} + r.operand_a;
        end else begin
            r.operand_a = {16'h0000, w16};
        end
        return r;
    endfunction

    // Advances the bench's decoder by one accepted code byte and queues the
    // record that the byte causes, if any.
    function automatic void decode_byte(input logic [7:0] code, input logic last);
        bcd_class_t  c;
        bcd_result_t r;
        logic        have;
        have = 1'b0;
        r = '0;
        if (halt_q) begin
            // The rest of an array after an invalid opcode is swallowed.
            if (last)
                decoder_clear();
            return;
        end
        live_bytes++;
        if (need_q == 3'd0) begin
            c = op_class(code);
            start_q = pos_q;
            if (c.len == LEN_INVALID || c.len == LEN_ONE) begin
                r.instr_offset = pos_q;
                r.opcode = code;
                r.instr_length = LEN_ONE;
                r.operand_kind = KIND_NONE;
                r.status = (c.len == LEN_INVALID) ? STAT_INVALID : STAT_OK;
                r.stream_end = last;
                have = 1'b1;
                if (c.len == LEN_INVALID && !last)
                    halt_q = 1'b1;
            end else begin
                held_q = code;
                wide_q = (code == OP_WIDE);
                need_q = c.len - 3'd1;
                opnd_q = '0;
                got_q = '0;
            end
        end else begin
            opnd_q = {opnd_q[31:0], code};
            got_q = got_q + 3'd1;
            need_q = need_q - 3'd1;
            // A wide iinc carries two more bytes for its 16-bit constant.
            if (wide_q && got_q == 3'd1 && code == OP_IINC)
                need_q = need_q + 3'd2;
            if (need_q == 3'd0) begin
                r = completed_instr(last);
                have = 1'b1;
                held_q = '0;
                wide_q = 1'b0;
                opnd_q = '0;
                got_q = '0;
            end
        end
        pos_q = pos_q + 16'd1;
        if (last) begin
            if (!have && need_q != 3'd0) begin
                // Truncated instruction: only what is known so far is reported.
                c = op_class(held_q);
                r = '0;
                r.instr_offset = start_q;
                r.opcode = (wide_q && got_q >= 3'd1) ? opnd_byte(1) : held_q;
                r.wide_prefix = wide_q;
                r.instr_length = got_q + 3'd1;
                r.operand_kind = c.kind;
                r.status = STAT_TRUNC;
                r.stream_end = 1'b1;
                have = 1'b1;
            end
            decoder_clear();
        end
        if (have)
            expected_instrs.push_back(r);
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic logic [7:0] common_op(input int idx);
        case (idx)
            0:  return OP_NOP;
            1:  return OP_DCONST_1;
            2:  return OP_BIPUSH;
            3:  return OP_SIPUSH;
            4:  return OP_LDC;
            5:  return OP_LDC_W;
            6:  return OP_LDC2_W;
            7:  return OP_ILOAD;
            8:  return OP_ASTORE;
            9:  return OP_RET;
            10: return OP_IINC;
            11: return OP_IFEQ;
            12: return OP_GOTO;
            13: return OP_JSR;
            14: return OP_IFNONNULL;
            15: return OP_GOTO_W;
            16: return OP_JSR_W;
            17: return OP_GETSTATIC;
            18: return OP_INVOKEIFACE;
            19: return OP_NEWARRAY;
            20: return OP_MULTIANEW;
            21: return OP_WIDE;
            22: return OP_RETURN;
            default: return OP_TABLESWITCH;
        endcase
    endfunction

    // Appends one instruction with random operands to the code buffer. With
    // allow_bad clear, opcodes that stop the decoder are drawn again.
    function automatic void add_instr(input logic allow_bad);
        logic [7:0] op;
        logic [7:0] inner;
        logic [7:0] b;
        bcd_class_t c;
        int         n;
        do begin
            if ($urandom_range(9) == 0)
                op = rand_byte();
            else
                op = common_op($urandom_range(23));
            c = op_class(op);
        end while (!allow_bad && c.len == LEN_INVALID);
        code_buf.push_back(op);
        n = (c.len > LEN_ONE) ? int'(c.len) - 1 : 0;
        if (op == OP_WIDE) begin
            inner = $urandom_range(1) ? OP_IINC : rand_byte();
            code_buf.push_back(inner);
            n = (inner == OP_IINC) ? 4 : 2;
        end
        for (int i = 0; i < n; i++) begin
            b = rand_byte();
            // Mostly a well-formed reserved byte, sometimes a nonzero one.
            if (op == OP_INVOKEIFACE && i == n - 1 && $urandom_range(3) != 0)
                b = 8'h00;
            code_buf.push_back(b);
        end
    endfunction

    // A random array: mostly complete instructions, now and then cut short
    // inside its last instruction or followed by stray bytes.
    function automatic void build_random_array();
        int         n;
        int         cut;
        int         last_start;
        logic [7:0] dropped;
        code_buf.delete();
        last_start = 0;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            last_start = code_buf.size();
            add_instr(1'b1);
        end
        case ($urandom_range(9))
            0: begin
                if (code_buf.size() - last_start > 1) begin
                    cut = $urandom_range(last_start + 1, code_buf.size() - 1);
                    while (code_buf.size() > cut)
                        dropped = code_buf.pop_back();
                end
            end
            1: begin
                repeat ($urandom_range(1, 4)) code_buf.push_back(rand_byte());
            end
            default: ;
        endcase
    endfunction

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // Offers one code byte and returns at the edge where it is accepted.
    task automatic send_byte(input logic [7:0] code, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= code;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bytes_sent++;
        decode_byte(code, last);
    endtask

    task automatic send_code_buf();
        arrays_sent++;
        for (int i = 0; i < code_buf.size(); i++)
            send_byte(code_buf[i], i == code_buf.size() - 1);
    endtask

    // The sender stays quiet until every predicted record has come back.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (expected_instrs.size() != 0)
            @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    // Extremes of the operand fields, several operand shapes and the special
    // cases: reserved byte, invalid opcode with halt, truncation, wide.
    task automatic test_directed();
        set_idling(0, 0);
        arrays_sent++;
        send_byte(OP_BIPUSH, 1'b0);      send_byte(8'h80, 1'b0);
        send_byte(OP_IINC, 1'b0);        send_byte(8'hff, 1'b0);  send_byte(8'h80, 1'b0);
        send_byte(OP_WIDE, 1'b0);        send_byte(OP_IINC, 1'b0);
        send_byte(8'hff, 1'b0);          send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);          send_byte(8'h00, 1'b0);
        send_byte(OP_INVOKEIFACE, 1'b0); send_byte(8'h12, 1'b0);  send_byte(8'h34, 1'b0);
        send_byte(8'h01, 1'b0);          send_byte(8'h05, 1'b0);
        send_byte(OP_GOTO_W, 1'b0);      send_byte(8'h80, 1'b0);  send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);          send_byte(8'h00, 1'b0);
        send_byte(OP_NEWARRAY, 1'b0);    send_byte(8'hff, 1'b1);
        // tableswitch is rejected and the rest of its array is skipped.
        arrays_sent++;
        send_byte(OP_TABLESWITCH, 1'b0); send_byte(8'h00, 1'b0);  send_byte(8'h00, 1'b1);
        // A wide prefix alone, then an invalid opcode on the last byte.
        arrays_sent++;
        send_byte(OP_WIDE, 1'b1);
        arrays_sent++;
        send_byte(8'hff, 1'b1);
        wait_all_results();
    endtask

    // Branch targets near the ends of the 32-bit range: a goto_w of -1 lands
    // just before itself, a large positive one crosses the sign boundary and
    // a short goto reaches far below the start of the array.
    task automatic test_target_wrap();
        code_buf.delete();
        repeat (3) code_buf.push_back(OP_NOP);
        code_buf.push_back(OP_GOTO_W);
        repeat (4) code_buf.push_back(8'hff);
        code_buf.push_back(OP_GOTO_W);
        code_buf.push_back(8'h7f);
        repeat (3) code_buf.push_back(8'hff);
        code_buf.push_back(OP_GOTO);
        code_buf.push_back(8'h80);
        code_buf.push_back(8'h00);
        code_buf.push_back(OP_NOP);
        set_idling(0, 0);
        send_code_buf();
        wait_all_results();
    endtask

    // The receiver holds off for a long stretch while bytes keep coming, so
    // the result buffer fills and the input side has to stall.
    task automatic test_backpressure();
        int start;
        set_idling(0, 0);
        hold_req = HOLD_OFF_CYCLES;
        start = live_bytes;
        while (live_bytes - start < 60) begin
            build_random_array();
            send_code_buf();
        end
        wait_all_results();
    endtask

    task automatic run_random_arrays(input int count);
        int start;
        start = live_bytes;
        while (live_bytes - start < count) begin
            build_random_array();
            send_code_buf();
        end
        wait_all_results();
    endtask

    task automatic test_random_traffic();
        set_idling(0, 0);
        run_random_arrays(75);
        set_idling(48, 0);
        run_random_arrays(75);
        set_idling(0, 48);
        run_random_arrays(75);
        set_idling(27, 27);
        run_random_arrays(85);
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    int hold_left = 0;
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            err_count++;
            if (err_count <= MAX_SHOWN)
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Every accepted record is compared with the oldest prediction.
    always @(posedge aclk) begin : check_results
        bcd_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_instrs.size() == 0) begin
                err_count++;
                if (err_count <= MAX_SHOWN)
                    $display("%0t: unexpected result transaction, tdata %h", $time, m_tdata);
            end else begin
                want = expected_instrs.pop_front();
                check_field("instr_offset", {16'h0000, want.instr_offset},
                            32'(m_tdata[15:0]));
                check_field("opcode", {24'h000000, want.opcode}, 32'(m_tdata[23:16]));
                check_field("wide_prefix", {31'h0, want.wide_prefix}, 32'(m_tdata[24]));
                check_field("instr_length", {29'h0, want.instr_length},
                            32'(m_tdata[27:25]));
                check_field("operand_kind", {29'h0, want.operand_kind},
                            32'(m_tdata[30:28]));
                check_field("operand_a", want.operand_a, m_tdata[62:31]);
                check_field("operand_b", {16'h0000, want.operand_b}, 32'(m_tdata[78:63]));
                check_field("branch_target", want.branch_target, m_tdata[110:79]);
                check_field("tdata padding", 32'h0, 32'(m_tdata[111]));
                check_field("status", {30'h0, want.status}, 32'(m_tuser));
                check_field("stream_end", {31'h0, want.stream_end}, 32'(m_tlast));
            end
        end
    end

    // Watchdog: too long without any transaction means the block is stuck.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        decoder_clear();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_target_wrap();
        test_backpressure();
        test_random_traffic();
        wait_all_results();
        $display("Sent %0d code bytes in %0d arrays and checked %0d instruction records,",
                 bytes_sent, arrays_sent, results_seen);
        $display("with wrapping branch targets, a long receiver hold-off and four idle mixes.");
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", err_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/bcd_pkg.sv
hw/rtl/bcd_classify.sv
hw/rtl/bcd_decode.sv
hw/rtl/bcd_out_buf.sv
hw/rtl/bytecode_instruction_decoder.sv
tb/tb_bytecode_instruction_decoder.sv
